/* rtl/ctsr_pkg.sv */
// shared constants and elaboration-time helpers for the color temperature converter
`default_nettype none
package ctsr_pkg;

   localparam int FRAC     = 30;
   localparam int OUT_BITS = 16;
   localparam int IN_W     = 16;
   localparam int FIELD_W  = 16;
   localparam int DIV_W    = 63;

   localparam logic [FRAC:0] ONE = 31'h4000_0000;

   // pipeline depths of the three blocks
   localparam int DIV_LAT  = FRAC + 1;
   localparam int UV_LAT   = 3 + DIV_LAT;
   localparam int MIX_LAT  = 6 + DIV_LAT;
   localparam int ENC_LAT  = 71;
   localparam int PIPE_LAT = UV_LAT + MIX_LAT + ENC_LAT;

   // krystek fits, scaled by 1e15 (u) and 1e16 (v)
   localparam logic [63:0] POLY_C [0:3] = '{64'd860117757000000, 64'd1000000000000000,
                                            64'd3173987260000000, 64'd10000000000000000};
   localparam logic [63:0] POLY_A [0:3] = '{64'd154118254000, 64'd842420235000,
                                            64'd422806245000, 64'd289741816000};
   localparam logic [63:0] POLY_B [0:3] = '{64'd128641212, 64'd708145163,
                                            64'd420481691, 64'd1614560530};

   // linear srgb matrix times 1e7, row major
   localparam logic signed [25:0] SRGB_MAT [0:8] = '{
      26'sd32404542, -26'sd15371385, -26'sd4985314,
      -26'sd9692660, 26'sd18760108, 26'sd415560,
      26'sd556434, -26'sd2040259, 26'sd10572252};

   // c below this takes the linear segment of the transfer curve
   localparam logic [63:0] LIN_LIMIT_W = ((64'd31308 << 30) + 64'd9999999) / 64'd10000000;
   localparam logic [FRAC:0] LIN_LIMIT = LIN_LIMIT_W[FRAC:0];

   // reciprocals for exact floor division by small constants
   localparam logic [63:0] M25_SHORT_W = ((64'd1 << 32) + 64'd24) / 64'd25;
   localparam logic [63:0] M25_LONG_W  = ((64'd1 << 40) + 64'd24) / 64'd25;
   localparam logic [63:0] RECIP3_W    = ((64'd1 << 37) + 64'd2) / 64'd3;
   localparam logic [27:0] M25_SHORT   = M25_SHORT_W[27:0];
   localparam logic [35:0] M25_LONG    = M25_LONG_W[35:0];
   localparam logic [35:0] RECIP3      = RECIP3_W[35:0];

   function automatic logic [63:0] isqrt_c(input logic [63:0] n);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      int k;
      x = n;
      r = '0;
      b = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if (b > x) b = b >> 2;
      end
      for (k = 0; k < 32; k++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-(j+1)) in q30, the factor for fraction bit 29-j
   function automatic logic [FRAC:0] exp_root(input int j);
      logic [63:0] rt;
      int k;
      rt = isqrt_c(64'd1 << 61);
      for (k = 0; k < FRAC; k++) begin
         if (k < j) rt = isqrt_c(rt << FRAC);
      end
      return rt[FRAC:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/color_temperature_to_srgb.sv */
// top level: color temperature in kelvin to an srgb-encoded color word
//
//   channel   dir  tdata bits                                   meaning
//   req_      in   [15:0] temperature_k                         one temperature per word
//   rsp_      out  [15:0] red  [31:16] green  [47:32] blue     one color per word
//
// one word enters per cycle while the skid stage is empty; a result passes through
// the two divider chains in series, the log2 squaring chain and the exp2 chain.
// reset clears only the valid bits of the pipeline, output register and skid stage.
// the whole pipeline holds when the skid stage is full; the output register plus
// skid stage keep the input open for one more word while a result waits.
`default_nettype none
module color_temperature_to_srgb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] temperature_k
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [15:0] red, [31:16] green, [47:32] blue
);
   import ctsr_pkg::*;

   logic                        en;
   logic [PIPE_LAT-1:0]         vld_ff;
   logic [PIPE_LAT-1:0]         vld_in;
   logic [FRAC:0]               u;
   logic [FRAC:0]               v;
   logic [2:0][FRAC:0]          lin;
   logic [2:0][OUT_BITS-1:0]    code;
   logic [3*FIELD_W-1:0]        pipe_data;
   logic                        pipe_take;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [3*FIELD_W-1:0]        out_data_ff;
   logic [3*FIELD_W-1:0]        out_data_in;
   logic                        skid_valid_ff;
   logic                        skid_valid_in;
   logic [3*FIELD_W-1:0]        skid_data_ff;
   logic [3*FIELD_W-1:0]        skid_data_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   ctsr_uv u_uv (
      .clock (clock),
      .en    (en),
      .temp  (req_tdata[IN_W-1:0]),
      .u     (u),
      .v     (v)
   );

   ctsr_mix u_mix (
      .clock (clock),
      .en    (en),
      .u     (u),
      .v     (v),
      .lin   (lin)
   );

   for (genvar k = 0; k < 3; k++) begin : g_enc
      ctsr_enc u_enc (
         .clock (clock),
         .en    (en),
         .lin   (lin[k]),
         .code  (code[k])
      );
   end

   assign pipe_data = {FIELD_W'(code[2]), FIELD_W'(code[1]), FIELD_W'(code[0])};
   assign pipe_take = en && vld_ff[PIPE_LAT-1];

   always_comb begin
      vld_in        = en ? {vld_ff[PIPE_LAT-2:0], req_tvalid && req_tready} : vld_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = pipe_take;
            out_data_in  = pipe_data;
         end
      end else if (pipe_take) begin
         // output word still waiting: park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("skid word lost while output stalled");

   a_skid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(vld_ff[PIPE_LAT-1] && out_valid_ff && !rsp_tready))
      else $error("skid filled without a stalled output and a finished word");

endmodule
`default_nettype wire

/* rtl/ctsr_div.sv */
// pipelined restoring divider, one quotient bit per stage, q1.30 result
`default_nettype none
module ctsr_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [ctsr_pkg::DIV_W-1:0] num,
   input  logic [ctsr_pkg::DIV_W-1:0] den,
   output logic [ctsr_pkg::FRAC:0]   quo
);
   import ctsr_pkg::*;

   logic [DIV_W-1:0] rem_ff [0:FRAC];
   logic [DIV_W-1:0] den_ff [0:FRAC];
   logic [FRAC:0]    quo_ff [0:FRAC];
   logic             zero_ff [0:FRAC];

   // integer bit first, numerator stays below twice the divisor
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= den;
         zero_ff[0] <= (den == '0);
         if (num >= den) begin
            rem_ff[0] <= num - den;
            quo_ff[0] <= (FRAC+1)'(1);
         end else begin
            rem_ff[0] <= num;
            quo_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 1; k <= FRAC; k++) begin : g_step
      logic [DIV_W:0] shl;
      assign shl = {rem_ff[k-1], 1'b0};
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= den_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            if (shl >= {1'b0, den_ff[k-1]}) begin
               rem_ff[k] <= DIV_W'(shl - {1'b0, den_ff[k-1]});
               quo_ff[k] <= {quo_ff[k-1][FRAC-1:0], 1'b1};
            end else begin
               rem_ff[k] <= shl[DIV_W-1:0];
               quo_ff[k] <= {quo_ff[k-1][FRAC-1:0], 1'b0};
            end
         end
      end
   end

   assign quo = zero_ff[FRAC] ? '0 : quo_ff[FRAC];

endmodule
`default_nettype wire

/* rtl/ctsr_uv.sv */
// planckian locus fit: temperature to cie 1960 u and v in q30
`default_nettype none
module ctsr_uv (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ctsr_pkg::IN_W-1:0]  temp,
   output logic [ctsr_pkg::FRAC:0]    u,
   output logic [ctsr_pkg::FRAC:0]    v
);
   import ctsr_pkg::*;

   logic [IN_W-1:0] t_ff;
   logic [31:0]     t2_ff;
   logic [63:0]     pa_ff [0:3];
   logic [63:0]     pb_ff [0:3];
   logic [63:0]     poly_ff [0:3];

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= temp;
         t2_ff <= 32'(temp) * 32'(temp);
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= POLY_A[i] * 64'(t_ff);
            pb_ff[i] <= POLY_B[i] * 64'(t2_ff);
         end
         poly_ff[0] <= POLY_C[0] + pa_ff[0] + pb_ff[0];
         poly_ff[1] <= POLY_C[1] + pa_ff[1] + pb_ff[1];
         poly_ff[2] <= POLY_C[2] + pa_ff[2] + pb_ff[2];
         // the linear term of the v denominator is negative
         poly_ff[3] <= POLY_C[3] + pb_ff[3] - pa_ff[3];
      end
   end

   ctsr_div u_div_u (
      .clock (clock),
      .en    (en),
      .num   (poly_ff[0][DIV_W-1:0]),
      .den   (poly_ff[1][DIV_W-1:0]),
      .quo   (u)
   );

   ctsr_div u_div_v (
      .clock (clock),
      .en    (en),
      .num   (poly_ff[2][DIV_W-1:0]),
      .den   (poly_ff[3][DIV_W-1:0]),
      .quo   (v)
   );

endmodule
`default_nettype wire

/* rtl/ctsr_mix.sv */
// srgb matrix, max-channel normalization and the three channel divides
`default_nettype none
module ctsr_mix (
   input  logic                           clock,
   input  logic                           en,
   input  logic [ctsr_pkg::FRAC:0]        u,
   input  logic [ctsr_pkg::FRAC:0]        v,
   output logic [2:0][ctsr_pkg::FRAC:0]   lin
);
   import ctsr_pkg::*;

   localparam logic signed [35:0] FOUR_ONE = 36'sd4294967296;

   logic signed [35:0] uu;
   logic signed [35:0] vv;
   logic signed [35:0] comp_ff [0:2];
   logic signed [63:0] prod_ff [0:8];
   logic signed [35:0] c1_m2_ff;
   logic signed [35:0] c1_m3_ff;
   logic signed [63:0] w_m3_ff [0:2];
   logic signed [63:0] w_m4_ff [0:2];
   logic signed [63:0] w_m5_ff [0:2];
   logic signed [63:0] wmax_ff;
   logic signed [63:0] flo_ff;
   logic signed [63:0] div_ff;
   logic [DIV_W-1:0]   num_ff [0:2];
   logic [DIV_W-1:0]   den_ff;

   assign uu = $signed(36'(u));
   assign vv = $signed(36'(v));

   // xyz scaled by the shared divisor and 1/y: (3u, 2v, 4-u-10v)
   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff[0] <= 36'sd3 * uu;
         comp_ff[1] <= 36'sd2 * vv;
         comp_ff[2] <= FOUR_ONE - uu - 36'sd10 * vv;
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= 64'(SRGB_MAT[i]) * 64'(comp_ff[i % 3]);
         end
         c1_m2_ff <= comp_ff[1];
         for (int k = 0; k < 3; k++) begin
            w_m3_ff[k] <= prod_ff[3*k] + prod_ff[3*k+1] + prod_ff[3*k+2];
         end
         c1_m3_ff <= c1_m2_ff;
         // brightness floor 1e-5 in these units is 100 * 2v
         flo_ff  <= 64'sd100 * 64'(c1_m3_ff);
         wmax_ff <= (w_m3_ff[1] > w_m3_ff[0]) ?
                    ((w_m3_ff[2] > w_m3_ff[1]) ? w_m3_ff[2] : w_m3_ff[1]) :
                    ((w_m3_ff[2] > w_m3_ff[0]) ? w_m3_ff[2] : w_m3_ff[0]);
         w_m4_ff <= w_m3_ff;
         div_ff  <= (wmax_ff >= flo_ff) ? wmax_ff : flo_ff;
         w_m5_ff <= w_m4_ff;
         // zero divisor or non-positive channel both give a zero quotient
         den_ff  <= (div_ff > 64'sd0) ? div_ff[DIV_W-1:0] : '0;
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= (w_m5_ff[k] > 64'sd0) ? w_m5_ff[k][DIV_W-1:0] : '0;
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_chan
      ctsr_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[k]),
         .den   (den_ff),
         .quo   (lin[k])
      );
   end

endmodule
`default_nettype wire

/* rtl/ctsr_enc.sv */
// srgb transfer curve for one channel: log2 by squaring, exp2 by root products
`default_nettype none
module ctsr_enc (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ctsr_pkg::FRAC:0]       lin,
   output logic [ctsr_pkg::OUT_BITS-1:0] code
);
   import ctsr_pkg::*;

   typedef struct packed {
      logic          flag;
      logic [FRAC:0] val;
   } lin_side_type;

   localparam logic [38:0] ELEVEN_ONE = 39'd11 << FRAC;
   localparam logic [FRAC+OUT_BITS:0] HALF = (FRAC+OUT_BITS+1)'(1) << (FRAC - 1);

   logic [3:0]    e_in;
   logic [FRAC:0] m_in;

   // linear segment
   logic          lf1_ff;
   logic          lf2_ff;
   logic [26:0]   ly1_ff;
   logic [25:0]   lb1_ff;
   logic [25:0]   lb2_ff;
   logic [54:0]   lp2_ff;
   lin_side_type  side_ff [3:69];

   // log2 by repeated squaring
   logic [FRAC:0]   lm_ff  [1:31];
   logic [FRAC-1:0] lfr_ff [1:31];
   logic [3:0]      le_ff  [1:31];

   logic [33:0]   nl;
   logic [36:0]   nl5;
   logic [34:0]   py_ff;
   logic [52:0]   ph_ff;
   logic [53:0]   pl_ff;
   logic [70:0]   psum;
   logic [2:0]    ip34_ff;
   logic [FRAC-1:0] fp34_ff;

   // exp2 of the fraction
   logic [FRAC:0]   xr_ff  [35:65];
   logic [FRAC-1:0] xg_ff  [35:65];
   logic [2:0]      xip_ff [35:65];
   logic            xfz_ff [35:65];

   logic [FRAC:0] root_ff;
   logic [38:0]   y211;
   logic [38:0]   ydiff;
   logic [34:0]   z_ff;
   logic          neg67_ff;
   logic          neg68_ff;
   logic [52:0]   zh_ff;
   logic [53:0]   zl_ff;
   logic [71:0]   zsum;
   logic [FRAC:0] snl_ff;
   logic [FRAC:0] s_ff;
   logic [FRAC:0] s_sel;
   logic [FRAC+OUT_BITS:0] wide;
   logic [OUT_BITS-1:0] code_ff;

   // shift that brings c into [1,2); c is at least 2^21 on the curve segment
   always_comb begin
      e_in = 4'd9;
      for (int k = 9; k >= 0; k--) begin
         if (lin[FRAC-k]) e_in = 4'(k);
      end
      m_in = lin << e_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lf1_ff       <= (lin < LIN_LIMIT);
         ly1_ff       <= 27'(32'd23 * 32'(lin[21:0]));
         lb1_ff       <= 26'(32'd12 * 32'(lin[21:0]));
         lf2_ff       <= lf1_ff;
         lb2_ff       <= lb1_ff;
         lp2_ff       <= 55'(ly1_ff) * 55'(M25_SHORT);
         // c*12.92 = 12c + floor(23c/25)
         side_ff[3].flag <= lf2_ff;
         side_ff[3].val  <= (FRAC+1)'(lb2_ff) + (FRAC+1)'(lp2_ff[54:32]);
         lm_ff[1]  <= m_in;
         lfr_ff[1] <= '0;
         le_ff[1]  <= e_in;
      end
   end

   for (genvar k = 4; k <= 69; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) side_ff[k] <= side_ff[k-1];
      end
   end

   for (genvar k = 2; k <= 31; k++) begin : g_log
      localparam int BIT = 31 - k;
      logic [61:0] sq;
      assign sq = 62'(lm_ff[k-1]) * 62'(lm_ff[k-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            le_ff[k] <= le_ff[k-1];
            if (sq[61]) begin
               lm_ff[k]  <= sq[61:31];
               lfr_ff[k] <= lfr_ff[k-1] | (FRAC'(1) << BIT);
            end else begin
               lm_ff[k]  <= sq[60:30];
               lfr_ff[k] <= lfr_ff[k-1];
            end
         end
      end
   end

   // -log2 c times 5/12: floor(floor(5 nl / 4) / 3)
   assign nl   = {le_ff[31], FRAC'(0)} - 34'(lfr_ff[31]);
   assign nl5  = {1'b0, nl, 2'b00} + 37'(nl);
   assign psum = {ph_ff, 18'd0} + 71'(pl_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         py_ff   <= nl5[36:2];
         ph_ff   <= 53'(py_ff[34:18]) * 53'(RECIP3);
         pl_ff   <= 54'(py_ff[17:0]) * 54'(RECIP3);
         ip34_ff <= psum[69:67];
         fp34_ff <= psum[66:37];
         xr_ff[35]  <= ONE;
         xg_ff[35]  <= FRAC'(ONE - (FRAC+1)'(fp34_ff));
         xip_ff[35] <= ip34_ff;
         xfz_ff[35] <= (fp34_ff == '0);
      end
   end

   for (genvar k = 36; k <= 65; k++) begin : g_exp
      localparam int BIT = 65 - k;
      localparam logic [FRAC:0] RT = exp_root(k - 36);
      logic [61:0] pr;
      assign pr = 62'(xr_ff[k-1]) * 62'(RT);
      always_ff @(posedge clock) begin
         if (en) begin
            xg_ff[k]  <= xg_ff[k-1];
            xip_ff[k] <= xip_ff[k-1];
            xfz_ff[k] <= xfz_ff[k-1];
            xr_ff[k]  <= xg_ff[k-1][BIT] ? pr[60:30] : xr_ff[k-1];
         end
      end
   end

   // 1.055 r - 0.055, that is (1055 r - 55) over 1000, reduces to floor((211 r - 11) / 200)
   assign y211  = 39'd211 * 39'(root_ff);
   assign ydiff = y211 - ELEVEN_ONE;
   assign zsum  = {1'b0, zh_ff, 18'd0} + 72'(zl_ff);

   always_comb begin
      s_sel = side_ff[69].flag ? side_ff[69].val : snl_ff;
   end

   assign wide = {s_ff, OUT_BITS'(0)} - (FRAC+OUT_BITS+1)'(s_ff) + HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff  <= xfz_ff[65] ? (ONE >> xip_ff[65]) : (xr_ff[65] >> (4'(xip_ff[65]) + 4'd1));
         neg67_ff <= (y211 < ELEVEN_ONE);
         z_ff     <= ydiff[37:3];
         neg68_ff <= neg67_ff;
         zh_ff    <= 53'(z_ff[34:18]) * 53'(M25_LONG);
         zl_ff    <= 54'(z_ff[17:0]) * 54'(M25_LONG);
         snl_ff   <= neg68_ff ? '0 : zsum[70:40];
         s_ff     <= (s_sel > ONE) ? ONE : s_sel;
         code_ff  <= wide[FRAC+OUT_BITS-1:FRAC];
      end
   end

   assign code = code_ff;

endmodule
`default_nettype wire
